@@ sv/hrhp_pkg.sv @@
`default_nettype none

package hrhp_pkg;

  // Header line limit; a header line whose index would reach it is an error.
  localparam int MAX_HEADERS = 64;
  localparam int HDR_CNT_W   = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1;
  localparam int HDR_IDX_W   = 6;

  // Delimiter characters.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Field kind tags on the result channel.
  typedef enum logic [2:0] {
    KIND_DELIM  = 3'd0,
    KIND_VER    = 3'd1,
    KIND_CODE   = 3'd2,
    KIND_REASON = 3'd3,
    KIND_NAME   = 3'd4,
    KIND_VALUE  = 3'd5,
    KIND_BODY   = 3'd6,
    KIND_ERR    = 3'd7
  } kind_t;

  // Parser phases, one-hot.
  typedef enum logic [15:0] {
    PH_VER0   = 16'h0001,
    PH_VER    = 16'h0002,
    PH_CODE0  = 16'h0004,
    PH_CODE   = 16'h0008,
    PH_RSN0   = 16'h0010,
    PH_RSN    = 16'h0020,
    PH_STLF   = 16'h0040,
    PH_HFIRST = 16'h0080,
    PH_NAME   = 16'h0100,
    PH_VAL0   = 16'h0200,
    PH_VAL    = 16'h0400,
    PH_VALLF  = 16'h0800,
    PH_LINE   = 16'h1000,
    PH_ENDLF  = 16'h2000,
    PH_BODY0  = 16'h4000,
    PH_BODY   = 16'h8000
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic [HDR_CNT_W-1:0] hdr_cnt;
    logic                 err;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_VER0, hdr_cnt: '0, err: 1'b0};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
  } in_word_t;

  typedef struct packed {
    kind_t                field_kind;
    logic                 field_start;
    logic [HDR_IDX_W-1:0] header_index;
    logic                 head_done;
    logic                 parse_error;
  } result_t;

  // Low bits of the header count, zero-extended when the count is narrower.
  function automatic logic [HDR_IDX_W-1:0] hdr_index(input logic [HDR_CNT_W-1:0] cnt);
    logic [HDR_CNT_W+HDR_IDX_W-1:0] ext;
    ext = {{HDR_IDX_W{1'b0}}, cnt};
    return ext[HDR_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/hrhp_if.sv @@
`default_nettype none

// Byte channel into the parser.
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_message;

  modport source (output valid, output data_byte, output new_message, input ready);
  modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

// Tagged result channel out of the parser.
interface hrhp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] field_kind;
  logic       field_start;
  logic [5:0] header_index;
  logic       head_done;
  logic       parse_error;

  modport source (output valid, output field_kind, output field_start,
                  output header_index, output head_done, output parse_error,
                  input ready);
  modport sink   (input valid, input field_kind, input field_start,
                  input header_index, input head_done, input parse_error,
                  output ready);
endinterface

`default_nettype wire

@@ sv/http_response_head_parser.sv @@
// Byte-serial parser for the head of an HTTP response.
// in_stream carries one received byte per word plus a new_message flag that
// restarts the parser at the status line before that byte is parsed.
// out_stream returns one tagged word per byte: field kind, field start,
// header line index, head-done and a sticky parse error.
// Both channels use valid/ready; a word moves when both are high.
// Throughput is one byte per cycle while out_stream takes results: the parser
// state loop is a single transition from the input register into the result
// register. An accepted word passes through the input register, is parsed into
// the result register and is on out_stream from then on until it is taken.
// When the receiver stalls, the result register holds its word, the input
// register takes one more byte, and in_stream.ready then drops until the
// result is taken.
// Reset (synchronous, rst_n low) empties both registers and returns the
// parser to the start of the status line with no headers and no error.
`default_nettype none

module http_response_head_parser (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hrhp_in_if.sink     in_stream,
  hrhp_out_if.source  out_stream
);
  import hrhp_pkg::*;

  logic     in_valid_r;
  in_word_t in_word_r;
  logic     out_valid_r;
  result_t  out_word_r;
  state_t   state_r;
  state_t   state_nxt;
  result_t  result_nxt;
  logic     advance;
  logic     in_take;

  // A buffered byte is parsed whenever the result register is free or drains.
  assign advance          = in_valid_r && (!out_valid_r || out_stream.ready);
  assign in_stream.ready  = !in_valid_r || advance;
  assign in_take          = in_stream.valid && in_stream.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      in_valid_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r.data_byte   <= in_stream.data_byte;
      in_word_r.new_message <= in_stream.new_message;
    end
  end

  // Parser transition.
  hrhp_step u_step (
    .state_i  (state_r),
    .word_i   (in_word_r),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result_nxt;
    end
  end

  assign out_stream.valid        = out_valid_r;
  assign out_stream.field_kind   = out_word_r.field_kind;
  assign out_stream.field_start  = out_word_r.field_start;
  assign out_stream.header_index = out_word_r.header_index;
  assign out_stream.head_done    = out_word_r.head_done;
  assign out_stream.parse_error  = out_word_r.parse_error;

  // The error stays set until a new message restarts the parser.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.err && !(advance && in_word_r.new_message) |=> state_r.err)
    else $error("parse error cleared without a new message");

  // An error word and the error flag always come together.
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_word_r.field_kind == KIND_ERR) == out_word_r.parse_error))
    else $error("error tag and error flag disagree");

  // Once the head is done, every good byte is body, apart from the LF that
  // ends the head, which is a delimiter.
  a_body_after_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.head_done && !out_word_r.parse_error
      |-> (out_word_r.field_kind == KIND_BODY || out_word_r.field_kind == KIND_DELIM))
    else $error("byte after head not tagged as body");

  // With the result register empty, the parser never refuses a byte.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_stream.ready)
    else $error("input stalled while result register empty");

endmodule

`default_nettype wire

@@ sv/hrhp_step.sv @@
`default_nettype none

// One parser transition: current state and one byte in, next state and the
// tagged result out. Purely combinational.
module hrhp_step (
  input  hrhp_pkg::state_t   state_i,
  input  hrhp_pkg::in_word_t word_i,
  output hrhp_pkg::state_t   state_o,
  output hrhp_pkg::result_t  result_o
);
  import hrhp_pkg::*;

  state_t               cur;
  state_t               nxt;
  kind_t                kind;
  logic                 start;
  logic                 bad;
  logic [7:0]           c;
  logic [HDR_CNT_W:0]   cnt_inc;
  logic                 too_many;
  logic                 is_sp;
  logic                 is_cr;
  logic                 is_lf;
  logic                 is_colon;

  assign c        = word_i.data_byte;
  assign is_sp    = (c == CH_SP);
  assign is_cr    = (c == CH_CR);
  assign is_lf    = (c == CH_LF);
  assign is_colon = (c == CH_COLON);

  // A new message restarts the parser before this byte is looked at.
  assign cur      = word_i.new_message ? STATE_RESET : state_i;
  assign cnt_inc  = {1'b0, cur.hdr_cnt} + {{HDR_CNT_W{1'b0}}, 1'b1};
  assign too_many = (cnt_inc >= (HDR_CNT_W+1)'(MAX_HEADERS));

  always_comb begin
    nxt   = cur;
    kind  = KIND_DELIM;
    start = 1'b0;
    bad   = 1'b0;

    if (cur.err) begin
      kind = KIND_ERR;
    end else begin
      unique case (cur.phase)
        PH_VER0, PH_VER: begin
          if (is_cr || is_lf || (cur.phase == PH_VER0 && is_sp)) begin
            bad = 1'b1;
          end else if (is_sp) begin
            nxt.phase = PH_CODE0;
          end else begin
            kind      = KIND_VER;
            start     = (cur.phase == PH_VER0);
            nxt.phase = PH_VER;
          end
        end
        PH_CODE0, PH_CODE: begin
          if (is_cr || is_lf) begin
            bad = 1'b1;
          end else if (is_sp) begin
            nxt.phase = PH_RSN0;
          end else begin
            kind      = KIND_CODE;
            start     = (cur.phase == PH_CODE0);
            nxt.phase = PH_CODE;
          end
        end
        PH_RSN0, PH_RSN: begin
          if (is_lf) begin
            bad = 1'b1;
          end else if (is_cr) begin
            nxt.phase = PH_STLF;
          end else begin
            kind      = KIND_REASON;
            start     = (cur.phase == PH_RSN0);
            nxt.phase = PH_RSN;
          end
        end
        PH_STLF: begin
          if (!is_lf) begin
            bad = 1'b1;
          end else begin
            nxt.phase = PH_HFIRST;
          end
        end
        PH_HFIRST, PH_LINE: begin
          // Start of a line: either the blank line or a new header.
          if (is_cr) begin
            nxt.phase = PH_ENDLF;
          end else if (is_sp || is_lf) begin
            bad = 1'b1;
          end else if (cur.phase == PH_LINE && too_many) begin
            bad = 1'b1;
          end else begin
            if (cur.phase == PH_LINE) begin
              nxt.hdr_cnt = cnt_inc[HDR_CNT_W-1:0];
            end
            if (is_colon) begin
              nxt.phase = PH_VAL0;
            end else begin
              kind      = KIND_NAME;
              start     = 1'b1;
              nxt.phase = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (is_cr || is_lf) begin
            bad = 1'b1;
          end else if (is_colon) begin
            nxt.phase = PH_VAL0;
          end else begin
            kind = KIND_NAME;
          end
        end
        PH_VAL0, PH_VAL: begin
          if (is_lf) begin
            bad = 1'b1;
          end else if (is_cr) begin
            nxt.phase = PH_VALLF;
          end else begin
            kind      = KIND_VALUE;
            start     = (cur.phase == PH_VAL0);
            nxt.phase = PH_VAL;
          end
        end
        PH_VALLF: begin
          if (!is_lf) begin
            bad = 1'b1;
          end else begin
            nxt.phase = PH_LINE;
          end
        end
        PH_ENDLF: begin
          if (!is_lf) begin
            bad = 1'b1;
          end else begin
            nxt.phase = PH_BODY0;
          end
        end
        PH_BODY0: begin
          kind      = KIND_BODY;
          start     = 1'b1;
          nxt.phase = PH_BODY;
        end
        default: begin
          kind      = KIND_BODY;
          nxt.phase = PH_BODY;
        end
      endcase
    end

    // The offending byte is tagged as error and the error sticks.
    if (bad) begin
      nxt.err = 1'b1;
      kind    = KIND_ERR;
      start   = 1'b0;
    end
  end

  assign state_o = nxt;

  assign result_o.field_kind   = kind;
  assign result_o.field_start  = start;
  assign result_o.header_index = hdr_index(nxt.hdr_cnt);
  assign result_o.head_done    = (nxt.phase == PH_BODY0) || (nxt.phase == PH_BODY);
  assign result_o.parse_error  = nxt.err;

endmodule

`default_nettype wire
